// ===== sv/edfs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the edf task scheduler
// no dependencies
package edfs_pkg;
   localparam int TASK_SLOTS  = 8;
   localparam int EVENT_LINES = 2;
   localparam int SLOT_W      = $clog2(TASK_SLOTS);
   localparam int LINE_W      = (EVENT_LINES > 1) ? $clog2(EVENT_LINES) : 1;

   typedef enum logic [2:0] {
      MODE_TICK     = 3'd0,
      MODE_ADD_PER  = 3'd1,
      MODE_ADD_EVT  = 3'd2,
      MODE_RAISE    = 3'd3,
      MODE_FINISH   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_FREE      = 2'd0,
      ST_STOPPED   = 2'd1,
      ST_SUSPENDED = 2'd2,
      ST_RUNNING   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_WALK, PH_DONE
   } phase_type;

   // command broadcast along the row of cells
   typedef struct packed {
      logic             tick;
      logic             add;
      logic             add_evt;
      logic [SLOT_W-1:0] add_slot;
      logic             raise;
      logic [SLOT_W-1:0] raise_slot;
      logic             finish;
      logic [SLOT_W-1:0] cur_slot;
      logic             sw;
      logic [SLOT_W-1:0] new_slot;
      logic [31:0]      period;
      logic [31:0]      offset;
      logic [31:0]      deadline;
   } cmd_type;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic             found;
      logic [31:0]      best;
      logic [SLOT_W-1:0] pick;
      logic             free_found;
      logic [SLOT_W-1:0] free_slot;
      logic             cur_stopped;
   } carry_type;
endpackage

// ===== sv/edfs_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying a payload word
// depends on nothing
interface edfs_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/edfs_cell.sv =====
`timescale 1ns / 1ps
// one task slot: holds its state, updates on commands, extends the carry chain
// depends on edfs_pkg
module edfs_cell import edfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] slot_id,
   input  cmd_type           cmd,
   input  logic              cmd_en,
   input  logic              scan_en,
   input  carry_type         carry_i,
   output carry_type         carry_o
);
   status_type  status_ff, status_in;
   logic [31:0] period_ff, period_in, offset_ff, offset_in, phase_ff, phase_in;
   logic [31:0] dl_ff, dl_in, dleft_ff, dleft_in;
   logic        mine;

   assign mine = (cmd.add_slot == slot_id);

   // tick update of this slot, then command handling
   always_comb begin
      status_type st;
      logic [31:0] ph_next;
      status_in = status_ff;
      period_in = period_ff;
      offset_in = offset_ff;
      phase_in  = phase_ff;
      dl_in     = dl_ff;
      dleft_in  = dleft_ff;
      ph_next   = phase_ff + 32'd1;
      st        = status_ff;
      if (cmd_en && cmd.tick) begin
         if (offset_ff != 32'd0) begin
            offset_in = offset_ff - 32'd1;
         end else if (period_ff != 32'd0) begin
            // phase counts up and wraps; phase < period except after an add
            if (phase_ff == 32'hFFFF_FFFF || ph_next >= period_ff)
               phase_in = (phase_ff == 32'hFFFF_FFFF) ? 32'd0 : ph_next - period_ff;
            else
               phase_in = ph_next;
            if (phase_in >= period_ff) phase_in = 32'd0;
         end
         if (phase_in == 32'd0 && st == ST_STOPPED) begin
            st       = ST_SUSPENDED;
            dleft_in = dl_ff;
         end
         if ((st == ST_SUSPENDED || st == ST_RUNNING) && dleft_in != 32'd0)
            dleft_in = dleft_in - 32'd1;
         status_in = st;
      end else if (cmd_en && cmd.sw) begin
         if (cmd.new_slot == slot_id) status_in = ST_RUNNING;
         else if (cmd.cur_slot == slot_id && status_ff == ST_RUNNING)
            status_in = ST_SUSPENDED;
      end else if (cmd_en && cmd.add && mine) begin
         status_in = ST_STOPPED;
         dl_in     = cmd.deadline;
         if (cmd.add_evt) begin
            period_in = 32'd0;
            offset_in = 32'd0;
            phase_in  = 32'd1;
         end else begin
            period_in = cmd.period;
            offset_in = cmd.offset;
            phase_in  = 32'hFFFF_FFFF;
         end
      end else if (cmd_en && cmd.raise && cmd.raise_slot == slot_id) begin
         status_in = ST_SUSPENDED;
         dleft_in  = dl_ff;
      end else if (cmd_en && cmd.finish && cmd.cur_slot == slot_id) begin
         status_in = ST_STOPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_FREE;
         period_ff <= 32'd1;
         offset_ff <= 32'd0;
         phase_ff  <= 32'd0;
         dl_ff     <= 32'd0;
         dleft_ff  <= 32'd0;
      end else begin
         status_ff <= status_in;
         period_ff <= period_in;
         offset_ff <= offset_in;
         phase_ff  <= phase_in;
         dl_ff     <= dl_in;
         dleft_ff  <= dleft_in;
      end
   end

   // scan step: min search, first free slot, current slot state
   always_comb begin
      logic act;
      carry_o = carry_i;
      act = (status_ff == ST_SUSPENDED || status_ff == ST_RUNNING);
      if (scan_en) begin
         if (act && offset_ff == 32'd0 && (!carry_i.found || dleft_ff < carry_i.best)) begin
            carry_o.found = 1'b1;
            carry_o.best  = dleft_ff;
            carry_o.pick  = slot_id;
         end
         if (!carry_i.free_found && status_ff == ST_FREE) begin
            carry_o.free_found = 1'b1;
            carry_o.free_slot  = slot_id;
         end
         if (cmd.cur_slot == slot_id) carry_o.cur_stopped = (status_ff == ST_STOPPED);
      end
   end
endmodule

// ===== sv/edf_task_scheduler.sv =====
`timescale 1ns / 1ps
// edf task scheduler: a row of slot cells scanned one per cycle
// depends on edfs_pkg, edfs_if, edfs_cell
//
// usage: req carries {mode, period, lead_ticks, deadline, event_line};
// rsp carries {running_slot, switched, add_failed, added_slot}, one word per
// req word. a req word is taken only when the block is idle. the block then
// walks the slots 1..TASK_SLOTS-1 one cell per cycle, collecting the first
// free slot, the least remaining deadline among ready tasks and the state of
// the running slot; a tick first updates every cell at once, on accept.
// steps: accept (with the tick update), the walk over the cells, then a done
// step that issues the command and registers the rsp word; the next req is
// taken only after that rsp word has been handed over.
// the slot 0 idle task is held by the top level itself.
// reset clears all slots to free, slot 0 running, event lines unbound.
// a stalled rsp holds its word; no new req is taken until it is delivered.
module edf_task_scheduler import edfs_pkg::*; (
   input logic clock,
   input logic reset,
   edfs_if.sink   req,
   edfs_if.source rsp
);
   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] period;
      logic [31:0] lead_ticks;
      logic [31:0] deadline;
      logic [0:0]  event_line;
   } req_type;
   typedef struct packed {
      logic [2:0] running_slot;
      logic       switched;
      logic       add_failed;
      logic [2:0] added_slot;
   } rsp_type;

   phase_type          ph_ff, ph_in;
   req_type            rq_ff, rq_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in, cur_ff, cur_in;
   logic [SLOT_W-1:0]  bind_ff [EVENT_LINES];
   logic [SLOT_W-1:0]  bind_in [EVENT_LINES];
   carry_type          acc_ff, acc_in;
   logic               s0run_ff, s0run_in;
   rsp_type            out_ff, out_in;
   logic               ovalid_ff, ovalid_in;
   cmd_type            cmd;
   logic               upd;
   carry_type          chain [TASK_SLOTS];
   logic               scan_en [TASK_SLOTS];
   logic               line_ok;

   assign req.ready = (ph_ff == PH_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;
   assign line_ok = ({31'd0, rq_ff.event_line} < EVENT_LINES);

   genvar g;
   generate
      for (g = 1; g < TASK_SLOTS; g++) begin : g_cell
         if (g == 1) begin : g_first
            assign chain[g-1] = acc_ff;
         end
         assign scan_en[g] = (ph_ff == PH_WALK) && (idx_ff == SLOT_W'(g));
         edfs_cell u_cell (
            .clock(clock), .reset(reset), .slot_id(SLOT_W'(g)), .cmd(cmd),
            .cmd_en(upd), .scan_en(scan_en[g]), .carry_i(chain[g-1]),
            .carry_o(chain[g])
         );
      end
   endgenerate
   assign scan_en[0] = 1'b0;

   always_comb begin
      logic pick_sw, stop_sw, add_ok;
      logic [SLOT_W-1:0] rs;
      ph_in = ph_ff; rq_in = rq_ff; idx_in = idx_ff; cur_in = cur_ff;
      bind_in = bind_ff; acc_in = acc_ff; s0run_in = s0run_ff;
      out_in = out_ff; ovalid_in = ovalid_ff;
      cmd = '0; upd = 1'b0;
      cmd.cur_slot = cur_ff;
      cmd.period = rq_ff.period; cmd.offset = rq_ff.lead_ticks;
      cmd.deadline = rq_ff.deadline;
      rs = bind_ff[rq_ff.event_line[LINE_W-1:0]];
      pick_sw = (acc_ff.found ? acc_ff.pick : '0) != cur_ff;
      stop_sw = (cur_ff == '0) ? !s0run_ff : acc_ff.cur_stopped;
      add_ok = acc_ff.free_found && !(rq_ff.mode == MODE_ADD_EVT && !line_ok);
      if (rsp.ready && ovalid_ff) ovalid_in = 1'b0;
      case (ph_ff)
         PH_IDLE: begin
            if (req.valid && req.ready) begin
               rq_in = req.payload;
               idx_in = SLOT_W'(1);
               acc_in = '0;
               ph_in = PH_WALK;
               if (req.payload.mode == MODE_TICK) begin
                  cmd.tick = 1'b1; upd = 1'b1;
               end
            end
         end
         PH_WALK: begin
            acc_in = chain[TASK_SLOTS-1];
            if (idx_ff == SLOT_W'(TASK_SLOTS-1)) ph_in = PH_DONE;
            else idx_in = idx_ff + SLOT_W'(1);
         end
         PH_DONE: begin
            out_in = '0;
            upd = 1'b1;
            case (rq_ff.mode)
               MODE_TICK: begin
                  if (pick_sw) begin
                     cmd.sw = 1'b1;
                     cmd.new_slot = acc_ff.found ? acc_ff.pick : '0;
                     cur_in = cmd.new_slot;
                     if (cur_ff == '0) s0run_in = 1'b0;
                     if (cmd.new_slot == '0) s0run_in = 1'b1;
                     out_in.switched = 1'b1;
                  end else if (stop_sw) begin
                     cur_in = '0; s0run_in = 1'b1; out_in.switched = 1'b1;
                  end
               end
               MODE_ADD_PER, MODE_ADD_EVT: begin
                  if (add_ok) begin
                     cmd.add = 1'b1;
                     cmd.add_evt = (rq_ff.mode == MODE_ADD_EVT);
                     cmd.add_slot = acc_ff.free_slot;
                     out_in.added_slot = 3'(acc_ff.free_slot);
                     if (rq_ff.mode == MODE_ADD_EVT)
                        bind_in[rq_ff.event_line[LINE_W-1:0]] = acc_ff.free_slot;
                  end else begin
                     out_in.add_failed = 1'b1;
                  end
               end
               MODE_RAISE: begin
                  if (line_ok && rs != '0) begin
                     cmd.raise = 1'b1; cmd.raise_slot = rs;
                  end
               end
               MODE_FINISH: begin
                  if (cur_ff != '0) cmd.finish = 1'b1;
               end
               default: ;
            endcase
            out_in.running_slot = 3'(cur_in);
            ovalid_in = 1'b1;
            ph_in = PH_IDLE;
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         idx_ff <= '0;
         cur_ff <= '0;
         s0run_ff <= 1'b1;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < EVENT_LINES; i++) bind_ff[i] <= '0;
      end else begin
         ph_ff <= ph_in;
         idx_ff <= idx_in;
         cur_ff <= cur_in;
         s0run_ff <= s0run_in;
         ovalid_ff <= ovalid_in;
         bind_ff <= bind_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end
endmodule

// ===== sim/tb_sched_types.sv =====
`timescale 1ns / 1ps
// word layouts used on the scheduler request and response channels
// depends on edfs_pkg
package tb_sched_types;
   import edfs_pkg::*;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] period;
      logic [31:0] lead_ticks;
      logic [31:0] deadline;
      logic        event_line;
   } sched_req_type;

   typedef struct packed {
      logic [2:0] running_slot;
      logic       switched;
      logic       add_failed;
      logic [2:0] added_slot;
   } sched_rsp_type;
endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for edf_task_scheduler: random and directed words checked against
// an in-bench scheduler model; depends on edfs_pkg, edfs_if, tb_sched_types
module tb_top import edfs_pkg::*, tb_sched_types::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int CALM_TAIL   = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   edfs_if #(.payload_type(sched_req_type)) req ();
   edfs_if #(.payload_type(sched_rsp_type)) rsp ();

   edf_task_scheduler dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   // scheduler state tracked by the bench
   status_type  m_status[TASK_SLOTS];
   logic [31:0] m_period[TASK_SLOTS];
   logic [31:0] m_offset[TASK_SLOTS];
   logic [31:0] m_phase[TASK_SLOTS];
   logic [31:0] m_dl[TASK_SLOTS];
   logic [31:0] m_dl_left[TASK_SLOTS];
   logic [SLOT_W-1:0] m_binding[EVENT_LINES];
   logic [SLOT_W-1:0] m_current;

   sched_req_type pending_words[$];
   sched_rsp_type expected_rsps[$];
   int mismatches = 0;
   int n_ticks = 0, n_switches = 0, n_added = 0, n_refused = 0;
   int cycles = 0;

   function automatic bit slot_active(int s);
      return m_status[s] == ST_SUSPENDED || m_status[s] == ST_RUNNING;
   endfunction

   function automatic bit edf_tick();
      int pick;
      logic [31:0] best;
      bit found;
      pick = 0;
      best = '0;
      found = 0;
      for (int s = 1; s < TASK_SLOTS; s++) begin
         if (m_offset[s] != 0) m_offset[s] = m_offset[s] - 1;
         else if (m_period[s] != 0) m_phase[s] = (m_phase[s] + 32'd1) % m_period[s];
         if (m_phase[s] == 0 && m_status[s] == ST_STOPPED) begin
            m_status[s] = ST_SUSPENDED;
            m_dl_left[s] = m_dl[s];
         end
         if (slot_active(s) && m_dl_left[s] != 0) m_dl_left[s] = m_dl_left[s] - 1;
      end
      for (int s = 1; s < TASK_SLOTS; s++) begin
         if (slot_active(s) && m_offset[s] == 0 && (!found || m_dl_left[s] < best)) begin
            found = 1;
            best = m_dl_left[s];
            pick = s;
         end
      end
      if (pick != m_current) begin
         if (m_status[m_current] == ST_RUNNING) m_status[m_current] = ST_SUSPENDED;
         m_status[pick] = ST_RUNNING;
         m_current = SLOT_W'(pick);
         return 1;
      end
      if (m_status[m_current] == ST_STOPPED) begin
         m_current = 0;
         m_status[0] = ST_RUNNING;
         return 1;
      end
      return 0;
   endfunction

   function automatic sched_rsp_type edf_predict(sched_req_type w);
      sched_rsp_type r;
      int s;
      r = '0;
      case (w.mode)
         MODE_TICK: begin
            r.switched = edf_tick();
            n_ticks++;
            if (r.switched) n_switches++;
         end
         MODE_ADD_PER, MODE_ADD_EVT: begin
            s = 0;
            for (int i = TASK_SLOTS - 1; i >= 1; i--)
               if (m_status[i] == ST_FREE) s = i;
            if (s == 0 || (w.mode == MODE_ADD_EVT && w.event_line >= EVENT_LINES)) begin
               r.add_failed = 1'b1;
               n_refused++;
            end else begin
               m_status[s] = ST_STOPPED;
               m_dl[s] = w.deadline;
               if (w.mode == MODE_ADD_PER) begin
                  m_period[s] = w.period;
                  m_offset[s] = w.lead_ticks;
                  m_phase[s] = '1;
               end else begin
                  m_period[s] = '0;
                  m_offset[s] = '0;
                  m_phase[s] = 32'd1;
                  m_binding[w.event_line] = SLOT_W'(s);
               end
               r.added_slot = 3'(s);
               n_added++;
            end
         end
         MODE_RAISE: begin
            if (w.event_line < EVENT_LINES) begin
               s = m_binding[w.event_line];
               if (s != 0) begin
                  m_status[s] = ST_SUSPENDED;
                  m_dl_left[s] = m_dl[s];
               end
            end
         end
         MODE_FINISH: if (m_current != 0) m_status[m_current] = ST_STOPPED;
         default: ;
      endcase
      r.running_slot = m_current;
      return r;
   endfunction

   function automatic sched_req_type make_word(logic [2:0] mode, logic [31:0] per,
                                               logic [31:0] off, logic [31:0] dl,
                                               logic line);
      sched_req_type w;
      w.mode = mode;
      w.period = per;
      w.lead_ticks = off;
      w.deadline = dl;
      w.event_line = line;
      return w;
   endfunction

   // small values most of the time so tasks actually activate
   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   function automatic sched_req_type random_word();
      logic [2:0] mode;
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) mode = MODE_TICK;
      else if (r < 65) mode = MODE_FINISH;
      else if (r < 80) mode = MODE_RAISE;
      else if (r < 86) mode = MODE_ADD_PER;
      else if (r < 92) mode = MODE_ADD_EVT;
      else mode = 3'($urandom_range(5, 7));
      return make_word(mode, pick_field(), pick_field(), pick_field(), 1'($urandom));
   endfunction

   initial begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
         m_status[s] = ST_FREE;
         m_period[s] = 32'd1;
         m_offset[s] = '0;
         m_phase[s] = '0;
         m_dl[s] = '0;
         m_dl_left[s] = '0;
      end
      m_status[0] = ST_RUNNING;
      for (int e = 0; e < EVENT_LINES; e++) m_binding[e] = '0;
      m_current = '0;

      // directed opening: idle finish, unbound raise, every add flavor, full table
      pending_words.push_back(make_word(MODE_FINISH, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_RAISE, 0, 0, 0, 1'b1));
      pending_words.push_back(make_word(MODE_ADD_EVT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 1'b0));
      pending_words.push_back(make_word(MODE_RAISE, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_ADD_PER, 1, 0, 0, 1'b1));
      pending_words.push_back(make_word(MODE_ADD_PER, 3, 2, 5, 1'b0));
      pending_words.push_back(make_word(MODE_ADD_PER, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 1'b1));
      pending_words.push_back(make_word(MODE_ADD_PER, 0, 1, 2, 1'b0));
      pending_words.push_back(make_word(MODE_ADD_EVT, 0, 0, 32'hFFFF_FFFF, 1'b1));
      pending_words.push_back(make_word(MODE_ADD_PER, 2, 0, 1, 1'b0));
      pending_words.push_back(make_word(MODE_ADD_PER, 5, 5, 5, 1'b0));
      pending_words.push_back(make_word(MODE_ADD_EVT, 5, 5, 5, 1'b0));
      pending_words.push_back(make_word(MODE_RAISE, 0, 0, 0, 1'b1));
      for (int i = 0; i < 4; i++)
         pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_FINISH, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 1'b0));
      pending_words.push_back(make_word(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        1'b1));
      pending_words.push_back(make_word(3'd7, 0, 0, 0, 1'b0));
      for (int i = 0; i < 1800; i++) pending_words.push_back(random_word());

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && !req.valid && expected_rsps.size() == 0);
      repeat (3 * TASK_SLOTS) @(posedge clock);
      $display("run covered %0d ticks (%0d switches), %0d adds taken, %0d refused",
               n_ticks, n_switches, n_added, n_refused);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d words outstanding", mismatches, expected_rsps.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else if (!req.valid || req.ready) begin
         if (req_gap > 0) begin
            req.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            req_gap <= $urandom_range(0, 9);
         end else if (pending_words.size() > 0) begin
            req.valid <= 1'b1;
            req.payload <= pending_words.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response stall generator
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 9);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset) begin
         if (req.valid && req.ready) expected_rsps.push_back(edf_predict(req.payload));
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word %p", rsp.payload);
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp.payload) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %p got %p", want, rsp.payload);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end
endmodule
